// ===== hw/rtl/htbd_pkg.sv =====
// shared types, codes and constants of the code tree builder and decoder
`default_nettype none
package htbd_pkg;

  localparam int NODE_COUNT_DEF = 512;
  localparam int MAX_CODE_LEN   = 32;
  localparam int SYMBOL_WIDTH   = 8;
  localparam int CODE_W         = 32;
  localparam int LEN_W          = 6;
  localparam int BYTE_W         = 8;
  localparam int SYM_IO_W       = 8;
  localparam int IQ_DEPTH       = 2;
  localparam int OQ_DEPTH       = 4;

  // item modes
  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_DECODE  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_SYMBOL   = 2'd0;
  localparam logic [1:0] STAT_INS_DONE = 2'd1;
  localparam logic [1:0] STAT_INS_REJ  = 2'd2;
  localparam logic [1:0] STAT_MISSING  = 2'd3;

  typedef struct packed {
    logic [1:0]          mode;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_W-1:0]    code_length;
    logic [SYM_IO_W-1:0] symbol_in;
    logic [BYTE_W-1:0]   data_byte;
  } in_t;

  typedef struct packed {
    logic [SYM_IO_W-1:0] symbol_out;
    logic [1:0]          status;
    logic                last;
  } out_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REJECT,
    OP_DECODE,
    OP_RESTART
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_W-1:0]    code_length;
    logic [SYM_IO_W-1:0] symbol_in;
    logic [BYTE_W-1:0]   data_byte;
  } op_item_t;

  typedef struct packed {
    logic [SYM_IO_W-1:0] symbol_out;
    logic [1:0]          status;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_FIND,
    ST_CHECK,
    ST_ALLOC,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/huffman_tree_build_and_decode_core.sv =====
// top level of the code tree builder and decoder
// input channel: push/full with in_data; an item is taken when push is high and full low.
//   mode 0 inserts a code and its symbol, mode 1 decodes one byte msb first,
//   mode 2 puts the decode walk back at the root, mode 3 is dropped.
// result channel: empty/pop with out_data; last marks the final result of an item.
//   an insert gives one result, a decode byte zero to eight, a restart none.
// a two-entry item queue feeds the engine and a four-entry queue takes its results,
//   so either side can stall without stopping the other right away.
// decode: one dependent node table read per bit through the single read port sets the pace;
//   a symbol found before the last bit takes a step of its own.
// insert: the walk reads each existing node on the code path through that same port,
//   and each new node is then written into the table in a step of its own.
// the last result of an item is pushed from the hold register in the flush state that
//   follows the item's work; a result passes the item queue, engine and hold register first.
// reset clears the root node, sets the node count to one and the walk to the root;
//   the rest of the node table needs no clearing, so items are taken right after reset.
// when the result queue is full the engine halts and the item queue fills, then full rises.
`default_nettype none
module huffman_tree_build_and_decode_core
  import htbd_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  output logic       full,
  input  wire in_t   in_data,
  output logic       empty,
  input  wire logic  pop,
  output out_t       out_data
);

  logic      op_valid;
  op_item_t  op_item;
  logic      op_take;
  logic      res_push;
  out_t      res_data;
  logic      res_full;

  htbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_item  (op_item),
    .op_take  (op_take)
  );

  htbd_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_item  (op_item),
    .op_take  (op_take),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full)
  );

  htbd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/htbd_front.sv =====
// front end: classifies accepted items and queues them for the engine
`default_nettype none
module htbd_front
  import htbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_t      in_data,
  output logic          op_valid,
  output op_item_t      op_item,
  input  wire logic     op_take
);

  localparam int PW = $clog2(IQ_DEPTH);
  localparam int CW = $clog2(IQ_DEPTH + 1);

  op_item_t        q_r [IQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  op_item_t        cls;
  logic            keep;
  logic            do_wr, do_rd;

  always_comb begin
    cls.code_bits   = in_data.code_bits;
    cls.code_length = in_data.code_length;
    cls.symbol_in   = in_data.symbol_in;
    cls.data_byte   = in_data.data_byte;
    cls.op          = OP_RESTART;
    keep            = 1'b1;
    unique case (in_data.mode)
      MODE_INSERT: begin
        if (in_data.code_length == '0 ||
            in_data.code_length > LEN_W'(MAX_CODE_LEN)) begin
          cls.op = OP_REJECT;
        end else begin
          cls.op = OP_INSERT;
        end
      end
      MODE_DECODE:  cls.op = OP_DECODE;
      MODE_RESTART: cls.op = OP_RESTART;
      // unused mode has no effect and no result
      default:      keep = 1'b0;
    endcase
  end

  assign full     = (cnt_r == CW'(IQ_DEPTH));
  assign op_valid = (cnt_r != '0);
  assign op_item  = q_r[rd_ptr_r];
  assign do_wr    = push && !full && keep;
  assign do_rd    = op_take && op_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/htbd_back.sv =====
// back end: node table, insert walk with allocation, bit-serial decode walk
`default_nettype none
module htbd_back
  import htbd_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      op_valid,
  input  wire op_item_t  op_item,
  output logic           op_take,
  output logic           res_push,
  output out_t           res_data,
  input  wire logic      res_full
);

  localparam int IW   = $clog2(NODE_COUNT);
  localparam int UW   = $clog2(NODE_COUNT + 1);
  localparam int SW   = SYMBOL_WIDTH;
  localparam int EW   = 2 * IW + SW;
  localparam int SUMW = ((UW > LEN_W) ? UW : LEN_W) + 1;
  localparam logic [LEN_W-1:0] CODE_W_L = LEN_W'(CODE_W);

  // node entry: {left, right, symbol}, child index zero means no child
  logic [EW-1:0]   mem [NODE_COUNT];
  logic [EW-1:0]   mem_q_r;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [EW-1:0]   wr_data;

  logic [IW-1:0]   root_l_r, root_r_r;

  state_t          state_r, state_nxt;
  logic            cur_root_r, cur_root_nxt;
  logic            chk_r, chk_nxt;
  logic [IW-1:0]   walk_r, walk_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic            hold_v_r, hold_v_nxt;
  res_t            hold_r, hold_nxt;
  logic [IW-1:0]   node_r, node_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [3:0]      bits_r, bits_nxt;
  logic [SW-1:0]   sym_r, sym_nxt;
  logic [IW-1:0]   par_l_r, par_l_nxt;
  logic [IW-1:0]   par_r_r, par_r_nxt;
  logic [SW-1:0]   par_s_r, par_s_nxt;

  logic [IW-1:0]   cur_l, cur_r;
  logic [SW-1:0]   cur_s;
  logic            emit;
  res_t            new_res;
  logic            stall;
  logic            take;
  logic            bit_c, bit_d;
  logic [IW-1:0]   nx_c, nx_d;
  logic [SUMW-1:0] need;
  logic [IW-1:0]   new_idx, new_child;

  // current node: root from flops, any other node from the read register
  always_comb begin
    if (cur_root_r) begin
      cur_l = root_l_r;
      cur_r = root_r_r;
      cur_s = '0;
    end else begin
      cur_l = mem_q_r[EW-1 -: IW];
      cur_r = mem_q_r[EW-1-IW -: IW];
      cur_s = mem_q_r[SW-1:0];
    end
  end

  assign bit_c     = code_r[CODE_W-1];
  assign bit_d     = byte_r[BYTE_W-1];
  assign nx_c      = bit_c ? cur_r : cur_l;
  assign nx_d      = bit_d ? cur_r : cur_l;
  assign need      = SUMW'(used_r) + SUMW'(rem_r);
  assign new_idx   = IW'(used_r);
  assign new_child = IW'(used_r + UW'(1));

  always_comb begin
    state_nxt    = state_r;
    cur_root_nxt = cur_root_r;
    chk_nxt      = chk_r;
    walk_nxt     = walk_r;
    used_nxt     = used_r;
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    node_nxt     = node_r;
    code_nxt     = code_r;
    rem_nxt      = rem_r;
    byte_nxt     = byte_r;
    bits_nxt     = bits_r;
    sym_nxt      = sym_r;
    par_l_nxt    = par_l_r;
    par_r_nxt    = par_r_r;
    par_s_nxt    = par_s_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    emit         = 1'b0;
    new_res      = '0;
    take         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          take = 1'b1;
          unique case (op_item.op)
            OP_INSERT: begin
              code_nxt     = op_item.code_bits << (CODE_W_L - op_item.code_length);
              rem_nxt      = op_item.code_length;
              sym_nxt      = SW'(op_item.symbol_in);
              node_nxt     = '0;
              cur_root_nxt = 1'b1;
              state_nxt    = ST_FIND;
            end
            OP_REJECT: begin
              emit           = 1'b1;
              new_res.status = STAT_INS_REJ;
              state_nxt      = ST_FLUSH;
            end
            OP_DECODE: begin
              byte_nxt  = op_item.data_byte;
              bits_nxt  = 4'd8;
              chk_nxt   = 1'b0;
              state_nxt = ST_DEC;
              // an insert may have grown the walk node: fetch it again
              if (walk_r == '0) begin
                cur_root_nxt = 1'b1;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = walk_r;
                cur_root_nxt = 1'b0;
              end
            end
            OP_RESTART: begin
              walk_nxt  = '0;
              state_nxt = ST_FLUSH;
            end
            default: state_nxt = ST_FLUSH;
          endcase
        end
      end

      ST_DEC: begin
        if (chk_r && cur_s != '0) begin
          // node reached by the previous bit carries a symbol
          emit               = 1'b1;
          new_res.symbol_out = SYM_IO_W'(cur_s);
          new_res.status     = STAT_SYMBOL;
          walk_nxt           = '0;
          cur_root_nxt       = 1'b1;
          chk_nxt            = 1'b0;
          if (bits_r == '0) begin
            state_nxt = ST_FLUSH;
          end
        end else if (bits_r == '0) begin
          state_nxt = ST_FLUSH;
        end else begin
          byte_nxt = byte_r << 1;
          bits_nxt = bits_r - 4'd1;
          if (nx_d == '0) begin
            emit           = 1'b1;
            new_res.status = STAT_MISSING;
            walk_nxt       = '0;
            cur_root_nxt   = 1'b1;
            chk_nxt        = 1'b0;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = nx_d;
            walk_nxt     = nx_d;
            cur_root_nxt = 1'b0;
            chk_nxt      = 1'b1;
          end
        end
      end

      ST_FIND: begin
        if (rem_r == '0 || nx_c == '0) begin
          // walk ends at an existing node, or at the first missing branch
          par_l_nxt = cur_l;
          par_r_nxt = cur_r;
          par_s_nxt = cur_s;
          state_nxt = ST_CHECK;
        end else begin
          rd_en        = 1'b1;
          rd_addr      = nx_c;
          node_nxt     = nx_c;
          cur_root_nxt = 1'b0;
          code_nxt     = code_r << 1;
          rem_nxt      = rem_r - LEN_W'(1);
        end
      end

      ST_CHECK: begin
        if (need > SUMW'(NODE_COUNT)) begin
          emit           = 1'b1;
          new_res.status = STAT_INS_REJ;
          state_nxt      = ST_FLUSH;
        end else if (rem_r == '0) begin
          wr_en          = 1'b1;
          wr_addr        = node_r;
          wr_data        = {par_l_r, par_r_r, sym_r};
          emit           = 1'b1;
          new_res.status = STAT_INS_DONE;
          state_nxt      = ST_FLUSH;
        end else begin
          // hang the first new node under the node where the walk stopped
          wr_en     = 1'b1;
          wr_addr   = node_r;
          wr_data   = bit_c ? {par_l_r, new_idx, par_s_r} : {new_idx, par_r_r, par_s_r};
          code_nxt  = code_r << 1;
          rem_nxt   = rem_r - LEN_W'(1);
          state_nxt = ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        wr_en    = 1'b1;
        wr_addr  = new_idx;
        used_nxt = used_r + UW'(1);
        if (rem_r == '0) begin
          wr_data        = {{IW{1'b0}}, {IW{1'b0}}, sym_r};
          emit           = 1'b1;
          new_res.status = STAT_INS_DONE;
          state_nxt      = ST_FLUSH;
        end else begin
          wr_data  = bit_c ? {{IW{1'b0}}, new_child, {SW{1'b0}}}
                           : {new_child, {IW{1'b0}}, {SW{1'b0}}};
          code_nxt = code_r << 1;
          rem_nxt  = rem_r - LEN_W'(1);
        end
      end

      ST_FLUSH: begin
        if (!hold_v_r || !res_full) begin
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // newest result waits in the hold register until the next one shows or the flush state
    if (emit) begin
      hold_nxt   = new_res;
      hold_v_nxt = 1'b1;
    end
  end

  assign stall   = emit && hold_v_r && res_full;
  assign op_take = take && !stall;

  always_comb begin
    res_push            = 1'b0;
    res_data.symbol_out = hold_r.symbol_out;
    res_data.status     = hold_r.status;
    res_data.last       = (state_r == ST_FLUSH);
    if (hold_v_r && !res_full) begin
      res_push = emit || (state_r == ST_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cur_root_r <= 1'b1;
      chk_r      <= 1'b0;
      walk_r     <= '0;
      used_r     <= UW'(1);
      hold_v_r   <= 1'b0;
      root_l_r   <= '0;
      root_r_r   <= '0;
    end else if (!stall) begin
      state_r    <= state_nxt;
      cur_root_r <= cur_root_nxt;
      chk_r      <= chk_nxt;
      walk_r     <= walk_nxt;
      used_r     <= used_nxt;
      hold_v_r   <= hold_v_nxt;
      if (wr_en && wr_addr == '0) begin
        root_l_r <= wr_data[EW-1 -: IW];
        root_r_r <= wr_data[EW-1-IW -: IW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      hold_r  <= hold_nxt;
      node_r  <= node_nxt;
      code_r  <= code_nxt;
      rem_r   <= rem_nxt;
      byte_r  <= byte_nxt;
      bits_r  <= bits_nxt;
      sym_r   <= sym_nxt;
      par_l_r <= par_l_nxt;
      par_r_r <= par_r_nxt;
      par_s_r <= par_s_nxt;
    end
  end

  // node table, root lives in flops above
  always_ff @(posedge clk) begin
    if (wr_en && !stall && wr_addr != '0) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en && !stall) begin
      mem_q_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/htbd_outq.sv =====
// result queue between the engine and the result ports
`default_nettype none
module htbd_outq
  import htbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  res_push,
  input  wire out_t  res_data,
  output logic       res_full,
  output logic       empty,
  input  wire logic  pop,
  output out_t       out_data
);

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  out_t            q_r [OQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr, do_rd;

  assign res_full = (cnt_r == CW'(OQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign out_data = q_r[rd_ptr_r];
  assign do_wr    = res_push && !res_full;
  assign do_rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(do_wr) - CW'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= res_data;
    end
  end

endmodule
`default_nettype wire
